// ===== hw/rtl/stpd_pkg.sv =====
package stpd_pkg;

  localparam int COORD_WIDTH_DEF  = 13;
  localparam int LENGTH_WIDTH_DEF = 12;
  localparam int ORIGIN_W         = 12;
  localparam int LEN_IN_W         = 12;
  localparam int BYTE_W           = 8;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;
  localparam int ISO_BYTES        = 256;
  localparam int ISO_ROWS         = 15;
  localparam int ISO_ROW_W        = 4;

  // Register index of decode_mode in the register map.
  localparam logic REG_DECODE_MODE = 1'b0;

  // decode_mode encodings.
  localparam logic MODE_ISO = 1'b0;
  localparam logic MODE_RLE = 1'b1;

  typedef enum logic [1:0] {
    PH_HDR_SKIP = 2'd0,
    PH_HDR_RUN  = 2'd1,
    PH_PIXEL    = 2'd2
  } phase_t;

  typedef struct packed {
    logic emit;
    logic discard;
  } stpd_stat_t;

  // First column of each diamond row.
  function automatic logic [BYTE_W-1:0] iso_start(input logic [ISO_ROW_W-1:0] r);
    logic [BYTE_W-1:0] v;
    case (r)
      4'd0:    v = 8'd14;
      4'd1:    v = 8'd12;
      4'd2:    v = 8'd10;
      4'd3:    v = 8'd8;
      4'd4:    v = 8'd6;
      4'd5:    v = 8'd4;
      4'd6:    v = 8'd2;
      4'd7:    v = 8'd0;
      4'd8:    v = 8'd2;
      4'd9:    v = 8'd4;
      4'd10:   v = 8'd6;
      4'd11:   v = 8'd8;
      4'd12:   v = 8'd10;
      4'd13:   v = 8'd12;
      4'd14:   v = 8'd14;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Pixel count of each diamond row.
  function automatic logic [BYTE_W-1:0] iso_count(input logic [ISO_ROW_W-1:0] r);
    logic [BYTE_W-1:0] v;
    case (r)
      4'd0:    v = 8'd4;
      4'd1:    v = 8'd8;
      4'd2:    v = 8'd12;
      4'd3:    v = 8'd16;
      4'd4:    v = 8'd20;
      4'd5:    v = 8'd24;
      4'd6:    v = 8'd28;
      4'd7:    v = 8'd32;
      4'd8:    v = 8'd28;
      4'd9:    v = 8'd24;
      4'd10:   v = 8'd20;
      4'd11:   v = 8'd16;
      4'd12:   v = 8'd12;
      4'd13:   v = 8'd8;
      4'd14:   v = 8'd4;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sub_tile_pixel_decoder_core.sv =====
// Sub-tile pixel decoder.
// Input channel (in_valid/in_ready) carries one data byte of a sub-tile per
// transaction; first_byte marks the byte that opens a sub-tile and samples
// tile_length, origin_x and origin_y. Output channel (out_valid/out_ready)
// carries one pixel (pixel_x, pixel_y, pixel_value) for each pixel byte;
// header bytes, bytes of a rejected sub-tile and bytes past its end produce
// nothing. The APB port holds decode_mode at address 0 (1 = run-length,
// 0 = isometric diamond); writing it abandons the sub-tile in progress.
// The pixel of a byte accepted at one edge is held in the output register and
// offered from the next cycle on. Throughput is one byte per cycle while the
// receiver takes the pixels. While the receiver stalls, the held pixel stays in
// the output register and a new byte is taken only in a cycle where that
// register empties. Reset sets run-length mode, clears the output register and
// leaves the decoder ignoring bytes until the next first byte.
module sub_tile_pixel_decoder_core
  import stpd_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   first_byte,
  input  logic [LEN_IN_W-1:0]    tile_length,
  input  logic [ORIGIN_W-1:0]    origin_x,
  input  logic [ORIGIN_W-1:0]    origin_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] pixel_x,
  output logic [COORD_WIDTH-1:0] pixel_y,
  output logic [BYTE_W-1:0]      pixel_value
);

  logic                   decode_mode;
  logic                   reg_index;
  logic                   cfg_write;
  logic                   take;
  stpd_stat_t             stat;
  logic [COORD_WIDTH-1:0] dec_x, dec_y;
  logic [BYTE_W-1:0]      dec_value;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready && (reg_index == REG_DECODE_MODE);
  assign prdata    = (reg_index == REG_DECODE_MODE) ? APB_DATA_W'(decode_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= MODE_RLE;
    end else if (cfg_write) begin
      decode_mode <= pwdata[0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  stpd_decode #(
    .COORD_WIDTH  (COORD_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .abort       (cfg_write),
    .mode        (decode_mode),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .tile_length (tile_length),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .stat        (stat),
    .pixel_x     (dec_x),
    .pixel_y     (dec_y),
    .pixel_value (dec_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= stat.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stat.emit) begin
      pixel_x     <= dec_x;
      pixel_y     <= dec_y;
      pixel_value <= dec_value;
    end
  end

  // A pixel only appears after a byte transaction.
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("pixel appeared without an accepted byte");

  // While ignoring bytes, a byte that does not open a sub-tile yields no pixel.
  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (take && !first_byte && stat.discard) |=> !out_valid)
    else $error("pixel produced from a discarded byte");

  // A mode write abandons the current sub-tile.
  a_cfg_aborts: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> stat.discard)
    else $error("mode write did not abandon the sub-tile");

endmodule

// ===== hw/rtl/stpd_decode.sv =====
module stpd_decode
  import stpd_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   abort,
  input  logic                   mode,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   first_byte,
  input  logic [LEN_IN_W-1:0]    tile_length,
  input  logic [ORIGIN_W-1:0]    origin_x,
  input  logic [ORIGIN_W-1:0]    origin_y,
  output stpd_stat_t             stat,
  output logic [COORD_WIDTH-1:0] pixel_x,
  output logic [COORD_WIDTH-1:0] pixel_y,
  output logic [BYTE_W-1:0]      pixel_value
);

  localparam int REM_W = LENGTH_WIDTH + 2;
  localparam int SUM_W = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;
  localparam logic [COORD_WIDTH-1:0]  COORD_MAX = '1;
  localparam logic [LENGTH_WIDTH-1:0] ISO_LEN   = LENGTH_WIDTH'(ISO_BYTES);

  phase_t                   phase, phase_next, c_phase;
  logic signed [REM_W-1:0]  remaining, remaining_next, c_rem;
  logic [COORD_WIDTH-1:0]   offset_x, offset_x_next, c_ox;
  logic [COORD_WIDTH-1:0]   row, row_next, c_row;
  logic [BYTE_W-1:0]        run_left, run_left_next, c_run;
  logic [BYTE_W-1:0]        skip_held, skip_held_next, c_skip;
  logic [ORIGIN_W-1:0]      base_x, base_x_next;
  logic [ORIGIN_W-1:0]      base_y, base_y_next;
  logic                     discard, discard_next, c_discard;

  logic [LENGTH_WIDTH-1:0]  len;
  logic [COORD_WIDTH:0]     ox_p1, ox_sk, row_p1;
  logic [COORD_WIDTH-1:0]   ox_p1_sat, ox_sk_sat, row_p1_sat;
  logic [BYTE_W-1:0]        run_dec;
  logic signed [REM_W-1:0]  rem_hdr, rem_run;
  logic [SUM_W-1:0]         sum_x, sum_y;
  logic                     emit;

  assign len = LENGTH_WIDTH'(tile_length);

  // A first byte reloads the sub-tile context before the byte itself is decoded.
  always_comb begin
    c_phase   = phase;
    c_rem     = remaining;
    c_ox      = offset_x;
    c_row     = row;
    c_run     = run_left;
    c_skip    = skip_held;
    c_discard = discard;
    base_x_next = base_x;
    base_y_next = base_y;
    if (first_byte) begin
      base_x_next = origin_x;
      base_y_next = origin_y;
      c_rem  = signed'({2'b00, len});
      c_row  = '0;
      c_skip = '0;
      if (mode == MODE_ISO) begin
        c_discard = (len != ISO_LEN);
        c_phase   = PH_PIXEL;
        c_ox      = COORD_WIDTH'(iso_start('0));
        c_run     = iso_count('0);
      end else begin
        c_discard = (len == '0);
        c_phase   = PH_HDR_SKIP;
        c_ox      = '0;
        c_run     = '0;
      end
    end
  end

  assign ox_p1      = {1'b0, c_ox} + (COORD_WIDTH + 1)'(1);
  assign ox_sk      = {1'b0, c_ox} + (COORD_WIDTH + 1)'(c_skip);
  assign row_p1     = {1'b0, c_row} + (COORD_WIDTH + 1)'(1);
  assign ox_p1_sat  = ox_p1[COORD_WIDTH] ? COORD_MAX : ox_p1[COORD_WIDTH-1:0];
  assign ox_sk_sat  = ox_sk[COORD_WIDTH] ? COORD_MAX : ox_sk[COORD_WIDTH-1:0];
  assign row_p1_sat = row_p1[COORD_WIDTH] ? COORD_MAX : row_p1[COORD_WIDTH-1:0];
  assign run_dec    = c_run - BYTE_W'(1);
  assign rem_hdr    = c_rem - REM_W'(2);
  assign rem_run    = rem_hdr - signed'(REM_W'(data_byte));

  always_comb begin
    phase_next     = c_phase;
    remaining_next = c_rem;
    offset_x_next  = c_ox;
    row_next       = c_row;
    run_left_next  = c_run;
    skip_held_next = c_skip;
    discard_next   = c_discard;
    emit           = 1'b0;
    if (!c_discard) begin
      if (mode == MODE_ISO) begin
        emit          = 1'b1;
        offset_x_next = ox_p1_sat;
        run_left_next = run_dec;
        if (run_dec == '0) begin
          // Row stays below the diamond height here, so the saturating
          // increment equals a plain one.
          row_next = row_p1_sat;
          if (row_p1_sat >= COORD_WIDTH'(ISO_ROWS)) begin
            discard_next = 1'b1;
          end else begin
            offset_x_next = COORD_WIDTH'(iso_start(row_p1_sat[ISO_ROW_W-1:0]));
            run_left_next = iso_count(row_p1_sat[ISO_ROW_W-1:0]);
          end
        end
      end else begin
        case (c_phase)
          PH_HDR_SKIP: begin
            skip_held_next = data_byte;
            phase_next     = PH_HDR_RUN;
          end
          PH_HDR_RUN: begin
            phase_next = PH_HDR_SKIP;
            if (c_skip != '0 || data_byte != '0) begin
              offset_x_next  = ox_sk_sat;
              remaining_next = rem_run;
              if (data_byte != '0) begin
                run_left_next = data_byte;
                phase_next    = PH_PIXEL;
              end else if (rem_run <= 0) begin
                discard_next = 1'b1;
              end
            end else begin
              // A zero pair ends the row.
              remaining_next = rem_hdr;
              offset_x_next  = '0;
              row_next       = row_p1_sat;
              if (rem_hdr <= 0) begin
                discard_next = 1'b1;
              end
            end
          end
          PH_PIXEL: begin
            emit          = 1'b1;
            offset_x_next = ox_p1_sat;
            run_left_next = run_dec;
            if (run_dec == '0) begin
              phase_next = PH_HDR_SKIP;
              if (c_rem <= 0) begin
                discard_next = 1'b1;
              end
            end
          end
          default: begin
            phase_next = PH_HDR_SKIP;
          end
        endcase
      end
    end
  end

  assign sum_x = SUM_W'(base_x_next) + SUM_W'(c_ox);
  assign sum_y = SUM_W'(base_y_next) + SUM_W'(c_row);
  assign pixel_x     = (sum_x > SUM_W'(COORD_MAX)) ? COORD_MAX : sum_x[COORD_WIDTH-1:0];
  assign pixel_y     = (sum_y > SUM_W'(COORD_MAX)) ? COORD_MAX : sum_y[COORD_WIDTH-1:0];
  assign pixel_value = data_byte;

  assign stat.emit    = emit;
  assign stat.discard = discard;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR_SKIP;
      remaining <= '0;
      offset_x  <= '0;
      row       <= '0;
      run_left  <= '0;
      skip_held <= '0;
      base_x    <= '0;
      base_y    <= '0;
      discard   <= 1'b1;
    end else if (abort) begin
      discard <= 1'b1;
    end else if (take) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      offset_x  <= offset_x_next;
      row       <= row_next;
      run_left  <= run_left_next;
      skip_held <= skip_held_next;
      base_x    <= base_x_next;
      base_y    <= base_y_next;
      discard   <= discard_next;
    end
  end

endmodule
